// ===== hw/rtl/m4vt_pkg.sv =====
// types and constants shared by the 4x4 matrix-vector transform block
// no dependencies
package m4vt_pkg;

	localparam int DIM    = 4;
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int IDX_W  = $clog2(DIM);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [PAIR_W-1:0] pair_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [IDX_W-1:0]         idx_t;

	typedef data_t [DIM-1:0]          row_t;
	typedef data_t [DIM*DIM-1:0]      matrix_t;

	typedef enum logic {
		KIND_LOAD      = 1'b0,
		KIND_TRANSFORM = 1'b1
	} kind_t;

	// load enables for the pipeline stages after the input register
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

// ===== hw/rtl/m4vt_in_if.sv =====
// input channel of the transform block: element load or vector word
// depends on m4vt_pkg
interface m4vt_in_if;
	logic              valid;
	logic              ready;
	logic              kind;
	m4vt_pkg::idx_t    elem_row;
	m4vt_pkg::idx_t    elem_col;
	m4vt_pkg::data_t   elem_value;
	m4vt_pkg::data_t   vec_x;
	m4vt_pkg::data_t   vec_y;
	m4vt_pkg::data_t   vec_z;
	m4vt_pkg::data_t   vec_w;

	modport source (
		output valid, kind, elem_row, elem_col, elem_value, vec_x, vec_y, vec_z, vec_w,
		input  ready
	);
	modport sink (
		input  valid, kind, elem_row, elem_col, elem_value, vec_x, vec_y, vec_z, vec_w,
		output ready
	);
endinterface

// ===== hw/rtl/m4vt_out_if.sv =====
// result channel of the transform block: transformed vector word
// depends on m4vt_pkg
interface m4vt_out_if;
	logic              valid;
	logic              ready;
	m4vt_pkg::data_t   out_x;
	m4vt_pkg::data_t   out_y;
	m4vt_pkg::data_t   out_z;
	m4vt_pkg::data_t   out_w;
	logic              saturated;

	modport source (
		output valid, out_x, out_y, out_z, out_w, saturated,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z, out_w, saturated,
		output ready
	);
endinterface

// ===== hw/rtl/m4vt_store.sv =====
// matrix register file, 16 elements row-major, reset to identity
// depends on m4vt_pkg
module m4vt_store #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  m4vt_pkg::idx_t    row,
	input  m4vt_pkg::idx_t    col,
	input  m4vt_pkg::data_t   wdata,
	output m4vt_pkg::matrix_t mat
);
	import m4vt_pkg::*;

	localparam data_t ONE = data_t'(1) << FRAC_BITS;

	matrix_t mat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM * DIM; i++) begin
				mat_q[i] <= (i % (DIM + 1) == 0) ? ONE : '0;
			end
		end else if (we) begin
			mat_q[{row, col}] <= wdata;
		end
	end

	assign mat = mat_q;
endmodule

// ===== hw/rtl/m4vt_row.sv =====
// one output lane: four products, adder tree, rounding and saturation
// depends on m4vt_pkg
module m4vt_row #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  m4vt_pkg::stage_en_t en,
	input  m4vt_pkg::row_t      coef,
	input  m4vt_pkg::row_t      vec,
	output m4vt_pkg::data_t     res,
	output logic                sat
);
	import m4vt_pkg::*;

	localparam sum_t  HALF  = sum_t'(1) << (FRAC_BITS - 1);
	localparam data_t MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
	localparam data_t MIN_V = {1'b1, {(DATA_W-1){1'b0}}};

	prod_t [DIM-1:0] prod_s2;
	pair_t [1:0]     pair_s3;
	sum_t            sum_s4;
	data_t           res_s5;
	logic            sat_s5;

	sum_t                     shifted;
	logic [SUM_W-DATA_W:0]    hi_bits;
	logic                     ovf;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int c = 0; c < DIM; c++) begin
				prod_s2[c] <= prod_t'($signed(coef[c])) * prod_t'($signed(vec[c]));
			end
		end
		if (en.s3) begin
			pair_s3[0] <= pair_t'(prod_s2[0]) + pair_t'(prod_s2[1]);
			pair_s3[1] <= pair_t'(prod_s2[2]) + pair_t'(prod_s2[3]);
		end
		// round half up before the shift
		if (en.s4) begin
			sum_s4 <= sum_t'(pair_s3[0]) + sum_t'(pair_s3[1]) + HALF;
		end
		if (en.s5) begin
			res_s5 <= ovf ? (shifted[SUM_W-1] ? MIN_V : MAX_V) : shifted[DATA_W-1:0];
			sat_s5 <= ovf;
		end
	end

	// in range when every bit from the data sign upward matches
	always_comb begin
		shifted = sum_s4 >>> FRAC_BITS;
		hi_bits = shifted[SUM_W-1:DATA_W-1];
		ovf     = !((&hi_bits) || !(|hi_bits));
	end

	assign res = res_s5;
	assign sat = sat_s5;
endmodule

// ===== hw/rtl/matrix4_vector_transform.sv =====
// 4x4 signed fixed-point matrix times vector, five-stage pipeline.
// a vector word passes the input register and stages s2 to s5 in order; result back-pressure can stall it.
// throughput: one word per cycle while the result channel does not stall; 16 parallel multipliers set the pace.
// a load word updates the matrix at its accept edge and is seen by the next vector.
// reset clears all stage valids and loads the identity matrix.
module matrix4_vector_transform #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	m4vt_in_if.sink     item,
	m4vt_out_if.source  result
);
	import m4vt_pkg::*;

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic acc, load_we;

	row_t      vec_s1;
	matrix_t   mat;
	stage_en_t en;
	row_t      res;
	logic [DIM-1:0] sat;

	// a stage takes new data when empty or when its content moves on
	assign rdy5 = !v5_s5 || result.ready;
	assign rdy4 = !v4_s4 || rdy5;
	assign rdy3 = !v3_s3 || rdy4;
	assign rdy2 = !v2_s2 || rdy3;
	assign rdy1 = !v1_s1 || rdy2;

	assign item.ready = rdy1;
	assign acc        = item.valid && rdy1;
	assign load_we    = acc && (item.kind == KIND_LOAD);

	assign en.s2 = rdy2 && v1_s1;
	assign en.s3 = rdy3 && v2_s2;
	assign en.s4 = rdy4 && v3_s3;
	assign en.s5 = rdy5 && v4_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_s1 <= item.valid && (item.kind == KIND_TRANSFORM);
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
			end
			if (rdy3) begin
				v3_s3 <= v2_s2;
			end
			if (rdy4) begin
				v4_s4 <= v3_s3;
			end
			if (rdy5) begin
				v5_s5 <= v4_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (item.kind == KIND_TRANSFORM)) begin
			vec_s1[0] <= item.vec_x;
			vec_s1[1] <= item.vec_y;
			vec_s1[2] <= item.vec_z;
			vec_s1[3] <= item.vec_w;
		end
	end

	m4vt_store #(
		.FRAC_BITS(FRAC_BITS)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (load_we),
		.row   (item.elem_row),
		.col   (item.elem_col),
		.wdata (item.elem_value),
		.mat   (mat)
	);

	for (genvar r = 0; r < DIM; r++) begin : g_row
		m4vt_row #(
			.FRAC_BITS(FRAC_BITS)
		) u_row (
			.clk (clk),
			.en  (en),
			.coef(mat[r*DIM +: DIM]),
			.vec (vec_s1),
			.res (res[r]),
			.sat (sat[r])
		);
	end

	assign result.valid     = v5_s5;
	assign result.out_x     = res[0];
	assign result.out_y     = res[1];
	assign result.out_z     = res[2];
	assign result.out_w     = res[3];
	assign result.saturated = |sat;
endmodule
